### design/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared types and constants of the search-tree child selector.
// ----------------------------------------------------------------------------
package mcs_pkg;

   localparam int MaxChildren = 256;
   localparam int CountBits   = 16;

   localparam logic [15:0] CountMask =
      (CountBits >= 16) ? 16'hFFFF : 16'((32'd1 << CountBits) - 32'd1);

   localparam logic [31:0] Ln2Q32         = 32'd2977044472;
   localparam logic [31:0] ScoreInf       = 32'hFFFF_FFFF;
   localparam logic [31:0] ScoreMaxFinite = 32'hFFFF_FFFE;

   localparam int LnBits = 20;

   localparam logic [1:0] ModeUct    = 2'd0;
   localparam logic [1:0] ModeRate   = 2'd1;
   localparam logic [1:0] ModeVisits = 2'd2;

   localparam logic [1:0] CsrMode = 2'd0;
   localparam logic [1:0] CsrExpC = 2'd1;

   localparam logic [15:0] ExpCReset = 16'd512;

   localparam int LogSteps  = 16;
   localparam int DivSteps  = 32;
   localparam int SqrtSteps = 24;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SKIP,
      CMD_LPT_ZERO,
      CMD_LOG_INIT,
      CMD_LOG_STEP,
      CMD_LN,
      CMD_LPT,
      CMD_DIV_INIT,
      CMD_DIV_STEP,
      CMD_SQRT_INIT,
      CMD_SQRT_STEP,
      CMD_UPDATE,
      CMD_EMIT
   } cmd_type;

   typedef struct packed {
      logic pos_full;
      logic pos_zero;
      logic p_zero;
      logic v_zero;
      logic mode_uct;
      logic mode_visits;
      logic last;
      logic out_busy;
   } status_type;

endpackage

### design/mcs_ctrl.sv
// ----------------------------------------------------------------------------
// mcs_ctrl
// Sequencer that steps the datapath through logarithm, divide and square root.
// ----------------------------------------------------------------------------
module mcs_ctrl
   import mcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_LOG,
      S_LN,
      S_LPT,
      S_SCORE,
      S_DIV,
      S_SQRT_INIT,
      S_SQRT,
      S_UPDATE,
      S_END
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.pos_full) begin
               cmd      = CMD_SKIP;
               state_in = S_END;
            end else if (status.pos_zero && status.p_zero) begin
               cmd      = CMD_LPT_ZERO;
               state_in = S_SCORE;
            end else if (status.pos_zero) begin
               cmd      = CMD_LOG_INIT;
               cnt_in   = 5'd0;
               state_in = S_LOG;
            end else begin
               state_in = S_SCORE;
            end
         end
         S_LOG: begin
            cmd    = CMD_LOG_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(LogSteps - 1)) begin
               state_in = S_LN;
            end
         end
         S_LN: begin
            cmd      = CMD_LN;
            state_in = S_LPT;
         end
         S_LPT: begin
            cmd      = CMD_LPT;
            state_in = S_SCORE;
         end
         S_SCORE: begin
            if (status.mode_visits || status.v_zero) begin
               state_in = S_UPDATE;
            end else begin
               cmd      = CMD_DIV_INIT;
               cnt_in   = 5'd0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd    = CMD_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DivSteps - 1)) begin
               state_in = status.mode_uct ? S_SQRT_INIT : S_UPDATE;
            end
         end
         S_SQRT_INIT: begin
            cmd      = CMD_SQRT_INIT;
            cnt_in   = 5'd0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd    = CMD_SQRT_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(SqrtSteps - 1)) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd      = CMD_UPDATE;
            state_in = S_END;
         end
         S_END: begin
            if (!status.last) begin
               state_in = S_IDLE;
            end else if (!status.out_busy) begin
               cmd      = CMD_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### design/mcs_dp.sv
// ----------------------------------------------------------------------------
// mcs_dp
// Datapath: operand registers, log unit, twin dividers on one divisor, square
// root, best child tracking and the result register.
// ----------------------------------------------------------------------------
module mcs_dp
   import mcs_pkg::*;
#(
   parameter int MAX_CHILDREN = MaxChildren
)
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic [15:0] req_child_wins,
   input  logic [15:0] req_child_visits,
   input  logic [15:0] req_parent_visits,
   input  logic        req_last_child,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_best_index,
   output logic [31:0] rsp_best_score,
   output logic        rsp_uct_error,
   output logic        rsp_too_many_children
);

   localparam int PosBits = $clog2(MAX_CHILDREN + 1);

   logic [1:0]  mode_ff, mode_in;
   logic [15:0] expc_ff, expc_in;
   logic [PosBits-1:0] pos_ff, pos_in;
   logic        err_ff, err_in;
   logic        ovf_ff, ovf_in;
   logic [7:0]  best_idx_ff, best_idx_in;
   logic [31:0] best_score_ff, best_score_in;
   logic        out_valid_ff, out_valid_in;

   logic [15:0] w_ff, w_in, v_ff, v_in, p_ff, p_in;
   logic        last_ff, last_in;
   logic [1:0]  imode_ff, imode_in;
   logic [3:0]  e_ff, e_in;
   logic [31:0] m_ff, m_in;
   logic [15:0] frac_ff, frac_in;
   logic [LnBits-1:0] ln_ff, ln_in;
   logic [31:0] lpt_ff, lpt_in;
   logic [16:0] rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [31:0] dq_a_ff, dq_a_in, dq_b_ff, dq_b_in;
   logic [47:0] sx_ff, sx_in;
   logic [23:0] root_ff, root_in;
   logic [25:0] srem_ff, srem_in;
   logic [7:0]  o_idx_ff, o_idx_in;
   logic [31:0] o_score_ff, o_score_in;
   logic        o_err_ff, o_err_in, o_ovf_ff, o_ovf_in;

   logic [15:0] win_m, vin_m;
   logic [3:0]  msb;
   logic [63:0] sq_prod;
   logic [32:0] sq;
   logic [51:0] ln_prod;
   logic [35:0] lpt_prod;
   logic [16:0] ta, tb;
   logic        qa, qb;
   logic [27:0] snew;
   logic [25:0] stest;
   logic [32:0] usum;
   logic [31:0] score;
   logic [PosBits+7:0] pos_ext;

   assign win_m = req_child_wins & CountMask;
   assign vin_m = req_child_visits & CountMask;

   always_comb begin
      msb = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (p_ff[i]) begin
            msb = 4'(i);
         end
      end
   end

   assign sq_prod  = 64'(m_ff) * 64'(m_ff);
   assign sq       = sq_prod[63:31];
   assign ln_prod  = 52'({e_ff, frac_ff}) * 52'(Ln2Q32);
   assign lpt_prod = 36'(expc_ff) * 36'(ln_ff);

   assign ta = {rem_a_ff[15:0], dq_a_ff[31]};
   assign tb = {rem_b_ff[15:0], dq_b_ff[31]};
   assign qa = (ta >= {1'b0, v_ff});
   assign qb = (tb >= {1'b0, v_ff});

   assign snew  = {srem_ff, sx_ff[47:46]};
   assign stest = {root_ff, 2'b01};

   assign usum = 33'(dq_a_ff) + 33'(root_ff);

   always_comb begin
      if (imode_ff[1]) begin
         score = 32'(v_ff);
      end else if (v_ff == 16'd0) begin
         score = (imode_ff == ModeUct) ? ScoreInf : 32'd0;
      end else if (imode_ff == ModeRate) begin
         score = dq_a_ff;
      end else if (usum > 33'(ScoreMaxFinite)) begin
         score = ScoreMaxFinite;
      end else begin
         score = usum[31:0];
      end
   end

   assign pos_ext = {8'd0, pos_ff};

   always_comb begin
      mode_in       = mode_ff;
      expc_in       = expc_ff;
      pos_in        = pos_ff;
      err_in        = err_ff;
      ovf_in        = ovf_ff;
      best_idx_in   = best_idx_ff;
      best_score_in = best_score_ff;
      out_valid_in  = out_valid_ff & ~rsp_ready;
      w_in = w_ff; v_in = v_ff; p_in = p_ff;
      last_in = last_ff; imode_in = imode_ff;
      e_in = e_ff; m_in = m_ff; frac_in = frac_ff;
      ln_in = ln_ff; lpt_in = lpt_ff;
      rem_a_in = rem_a_ff; rem_b_in = rem_b_ff;
      dq_a_in = dq_a_ff; dq_b_in = dq_b_ff;
      sx_in = sx_ff; root_in = root_ff; srem_in = srem_ff;
      o_idx_in = o_idx_ff; o_score_in = o_score_ff;
      o_err_in = o_err_ff; o_ovf_in = o_ovf_ff;

      if (csr_we) begin
         case (csr_index)
            CsrMode: mode_in = csr_wdata[1:0];
            CsrExpC: expc_in = csr_wdata;
            default: ;
         endcase
      end

      case (cmd)
         CMD_LOAD: begin
            w_in     = (win_m > vin_m) ? vin_m : win_m;
            v_in     = vin_m;
            p_in     = req_parent_visits & CountMask;
            last_in  = req_last_child;
            imode_in = mode_ff;
         end
         CMD_SKIP: begin
            ovf_in = 1'b1;
         end
         CMD_LPT_ZERO: begin
            lpt_in = 32'd0;
            if (imode_ff == ModeUct) begin
               err_in = 1'b1;
            end
         end
         CMD_LOG_INIT: begin
            e_in    = msb;
            m_in    = 32'({16'd0, p_ff} << (5'd31 - {1'b0, msb}));
            frac_in = 16'd0;
         end
         CMD_LOG_STEP: begin
            if (sq[32]) begin
               m_in    = sq[32:1];
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               m_in    = sq[31:0];
               frac_in = {frac_ff[14:0], 1'b0};
            end
         end
         CMD_LN: begin
            ln_in = ln_prod[51:32];
         end
         CMD_LPT: begin
            lpt_in = {4'd0, lpt_prod[35:8]};
         end
         CMD_DIV_INIT: begin
            rem_a_in = 17'd0;
            rem_b_in = 17'd0;
            dq_a_in  = {w_ff, 16'd0};
            dq_b_in  = lpt_ff;
         end
         CMD_DIV_STEP: begin
            rem_a_in = qa ? (ta - {1'b0, v_ff}) : ta;
            rem_b_in = qb ? (tb - {1'b0, v_ff}) : tb;
            dq_a_in  = {dq_a_ff[30:0], qa};
            dq_b_in  = {dq_b_ff[30:0], qb};
         end
         CMD_SQRT_INIT: begin
            sx_in   = {dq_b_ff, 16'd0};
            root_in = 24'd0;
            srem_in = 26'd0;
         end
         CMD_SQRT_STEP: begin
            sx_in = {sx_ff[45:0], 2'b00};
            if (snew >= 28'(stest)) begin
               srem_in = 26'(snew - 28'(stest));
               root_in = {root_ff[22:0], 1'b1};
            end else begin
               srem_in = snew[25:0];
               root_in = {root_ff[22:0], 1'b0};
            end
         end
         CMD_UPDATE: begin
            if (pos_ff == '0 || score > best_score_ff) begin
               best_idx_in   = pos_ext[7:0];
               best_score_in = score;
            end
            pos_in = pos_ff + PosBits'(1);
         end
         CMD_EMIT: begin
            o_idx_in      = best_idx_ff;
            o_score_in    = best_score_ff;
            o_err_in      = err_ff;
            o_ovf_in      = ovf_ff;
            out_valid_in  = 1'b1;
            pos_in        = '0;
            err_in        = 1'b0;
            ovf_in        = 1'b0;
            best_idx_in   = 8'd0;
            best_score_in = 32'd0;
            lpt_in        = 32'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= ModeUct;
         expc_ff       <= ExpCReset;
         pos_ff        <= '0;
         err_ff        <= 1'b0;
         ovf_ff        <= 1'b0;
         best_idx_ff   <= 8'd0;
         best_score_ff <= 32'd0;
         out_valid_ff  <= 1'b0;
         lpt_ff        <= 32'd0;
      end else begin
         mode_ff       <= mode_in;
         expc_ff       <= expc_in;
         pos_ff        <= pos_in;
         err_ff        <= err_in;
         ovf_ff        <= ovf_in;
         best_idx_ff   <= best_idx_in;
         best_score_ff <= best_score_in;
         out_valid_ff  <= out_valid_in;
         lpt_ff        <= lpt_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in; v_ff <= v_in; p_ff <= p_in;
      last_ff <= last_in; imode_ff <= imode_in;
      e_ff <= e_in; m_ff <= m_in; frac_ff <= frac_in; ln_ff <= ln_in;
      rem_a_ff <= rem_a_in; rem_b_ff <= rem_b_in;
      dq_a_ff <= dq_a_in; dq_b_ff <= dq_b_in;
      sx_ff <= sx_in; root_ff <= root_in; srem_ff <= srem_in;
      o_idx_ff <= o_idx_in; o_score_ff <= o_score_in;
      o_err_ff <= o_err_in; o_ovf_ff <= o_ovf_in;
   end

   assign status.pos_full    = (pos_ff == PosBits'(MAX_CHILDREN));
   assign status.pos_zero    = (pos_ff == '0);
   assign status.p_zero      = (p_ff == 16'd0);
   assign status.v_zero      = (v_ff == 16'd0);
   assign status.mode_uct    = (imode_ff == ModeUct);
   assign status.mode_visits = imode_ff[1];
   assign status.last        = last_ff;
   assign status.out_busy    = out_valid_ff & ~rsp_ready;

   assign rsp_valid             = out_valid_ff;
   assign rsp_best_index        = o_idx_ff;
   assign rsp_best_score        = o_score_ff;
   assign rsp_uct_error         = o_err_ff;
   assign rsp_too_many_children = o_ovf_ff;

endmodule

### design/mcts_child_selector.sv
// ----------------------------------------------------------------------------
// mcts_child_selector
// UCB1/UCT child selection over a stream of children of one tree node.
// ----------------------------------------------------------------------------
// The block takes one child per item and works on one item at a time. In
// visits mode or for an unvisited child no divide runs; in win-rate mode a
// child runs the 32-step twin dividers on one divisor, and in UCT mode also
// the 24-step square root. The first child of a pass with a nonzero parent
// count first runs the 16-step logarithm of the parent count. A child past
// the child limit only sets the overflow flag. The result of the last child
// is held in an output register, so the next pass starts while it waits to
// be taken; the last child of that next pass stalls until it is free.
module mcts_child_selector
   import mcs_pkg::*;
#(
   parameter int MAX_CHILDREN = MaxChildren
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_child_wins,
   input  logic [15:0] req_child_visits,
   input  logic [15:0] req_parent_visits,
   input  logic        req_last_child,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_best_index,
   output logic [31:0] rsp_best_score,
   output logic        rsp_uct_error,
   output logic        rsp_too_many_children
);

   cmd_type    cmd;
   status_type status;

   mcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mcs_dp #(
      .MAX_CHILDREN (MAX_CHILDREN)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_child_wins        (req_child_wins),
      .req_child_visits      (req_child_visits),
      .req_parent_visits     (req_parent_visits),
      .req_last_child        (req_last_child),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_best_index        (rsp_best_index),
      .rsp_best_score        (rsp_best_score),
      .rsp_uct_error         (rsp_uct_error),
      .rsp_too_many_children (rsp_too_many_children)
   );

endmodule

### dv/mcts_child_selector_tb.sv
// ----------------------------------------------------------------------------
// mcts_child_selector_tb
// Streams children of search-tree nodes into the selector and compares each
// selected child against a cycle-free model of UCT, win-rate and visit scoring.
// ----------------------------------------------------------------------------
module mcts_child_selector_tb;
   import mcs_pkg::*;

   typedef struct packed {
      logic [15:0] wins;
      logic [15:0] visits;
      logic [15:0] parent;
      logic        last;
   } child_type;

   typedef struct packed {
      logic [7:0]  index;
      logic [31:0] score;
      logic        err;
      logic        ovf;
   } pick_type;

   typedef struct {
      child_type   c;
      logic        chk;
      pick_type    want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_child_wins = '0;
   logic [15:0] req_child_visits = '0;
   logic [15:0] req_parent_visits = '0;
   logic        req_last_child = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_best_index;
   logic [31:0] rsp_best_score;
   logic        rsp_uct_error;
   logic        rsp_too_many_children;

   mcts_child_selector dut (.*);

   always #10 clock = ~clock;

   logic [1:0]  sel_mode;
   logic [15:0] exp_c;
   logic [7:0]  best_idx;
   logic [31:0] best_score;
   int unsigned position;
   logic [31:0] lpt;
   logic        err_seen, ovf_seen;

   pick_type    pending_picks[$];
   logic        pending_chk[$];
   pick_type    pending_want[$];
   int          errors = 0;
   int          picks_seen = 0;
   int          send_idle = 0, recv_idle = 0;
   logic        long_hold = 1'b0;

   function automatic logic [63:0] isqrt(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] ln_fixed(input logic [63:0] p);
      int e;
      logic [63:0] m, frac;
      e = 0;
      frac = 0;
      while (e < 31 && (p >> (e + 1)) != 0) e++;
      m = p << (31 - e);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return (((64'(e) << 16) | frac) * 64'(Ln2Q32)) >> 32;
   endfunction

   function automatic logic [63:0] child_score(input logic [63:0] w, input logic [63:0] v);
      logic [63:0] rate, s;
      if (sel_mode != ModeUct && sel_mode != ModeRate) return v;
      if (v == 0) return (sel_mode == ModeUct) ? 64'(ScoreInf) : 64'd0;
      rate = (w << 16) / v;
      if (sel_mode == ModeRate) return rate;
      s = rate + isqrt((64'(lpt) / v) << 16);
      return (s > 64'(ScoreMaxFinite)) ? 64'(ScoreMaxFinite) : s;
   endfunction

   task automatic predict_selection(input child_type c, output logic got, output pick_type o);
      logic [63:0] w, v, p, s;
      v = c.visits;
      w = (c.wins > c.visits) ? c.visits : c.wins;
      p = c.parent;
      got = 1'b0;
      o = '0;
      if (position >= MaxChildren) begin
         ovf_seen = 1'b1;
      end else begin
         if (position == 0) begin
            if (p == 0) begin
               lpt = 0;
               if (sel_mode == ModeUct) err_seen = 1'b1;
            end else begin
               lpt = 32'((64'(exp_c) * ln_fixed(p)) >> 8);
            end
         end
         s = child_score(w, v);
         if (position == 0 || s > 64'(best_score)) begin
            best_idx = position[7:0];
            best_score = s[31:0];
         end
         position++;
      end
      if (c.last) begin
         got = 1'b1;
         o = '{best_idx, best_score, err_seen, ovf_seen};
         best_idx = 0;
         best_score = 0;
         position = 0;
         lpt = 0;
         err_seen = 0;
         ovf_seen = 0;
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CsrMode) sel_mode = val[1:0];
      else exp_c = val;
      @(posedge clock);
   endtask

   task automatic drain_then_wait();
      int n;
      n = 0;
      while (pending_picks.size() != 0 && n < 200000) begin
         @(posedge clock);
         n++;
      end
      repeat (100) @(posedge clock);
   endtask

   task automatic send_child(input child_type c, input logic chk, input pick_type want);
      logic got;
      pick_type o;
      while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clock);
      req_valid <= 1'b1;
      {req_child_wins, req_child_visits, req_parent_visits, req_last_child} <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_selection(c, got, o);
      if (got) begin
         pending_picks.push_back(o);
         pending_chk.push_back(chk);
         pending_want.push_back(want);
      end
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic child_type random_child(input int n_left);
      child_type c;
      int k;
      k = $urandom_range(9);
      c.visits = (k < 2) ? 16'($urandom_range(0, 3)) : (k < 4) ? 16'($urandom) :
                 16'($urandom_range(0, 500));
      c.wins = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, c.visits));
      c.parent = ($urandom_range(14) == 0) ? 16'd0 : 16'($urandom);
      c.last = (n_left == 0);
      return c;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         picks_seen++;
         if (pending_picks.size() == 0) begin
            $display("%0t: unexpected result idx=%0d score=%h", $time, rsp_best_index,
                     rsp_best_score);
            errors++;
         end else begin
            pick_type e;
            logic ck;
            pick_type wv;
            e = pending_picks.pop_front();
            ck = pending_chk.pop_front();
            wv = pending_want.pop_front();
            if (ck && wv != e) begin
               $display("%0t: table row expected %h, predictor %h", $time, wv, e);
               errors++;
            end
            if (rsp_best_index != e.index || rsp_best_score != e.score ||
                rsp_uct_error != e.err || rsp_too_many_children != e.ovf) begin
               $display("%0t: expected idx=%0d score=%h err=%b ovf=%b, got idx=%0d score=%h err=%b ovf=%b",
                        $time, e.index, e.score, e.err, e.ovf, rsp_best_index,
                        rsp_best_score, rsp_uct_error, rsp_too_many_children);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (long_hold) rsp_ready <= 1'b0;
      else rsp_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
   end

   initial begin
      #200000000;
      $display("mcts_child_selector_tb: errors");
      $finish;
   end

   initial begin
      row_type table_rows[$];
      row_type r;
      int sent;
      int n_left;
      int hold;
      child_type c;
      pick_type none;
      none = '0;
      sel_mode = ModeUct;
      exp_c = ExpCReset;
      best_idx = 0; best_score = 0; position = 0; lpt = 0; err_seen = 0; ovf_seen = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: unvisited child is infinite, zero parent flags an error.
      table_rows.push_back('{'{16'd0, 16'd0, 16'd10, 1'b1}, 1'b1, '{8'd0, ScoreInf, 1'b0, 1'b0}});
      table_rows.push_back('{'{16'd5, 16'd5, 16'd0, 1'b1}, 1'b1, '{8'd0, 32'h10000, 1'b1, 1'b0}});
      table_rows.push_back('{'{16'd9, 16'd3, 16'd0, 1'b1}, 1'b1, '{8'd0, 32'h10000, 1'b1, 1'b0}});
      table_rows.push_back('{'{16'd1, 16'd4, 16'd1, 1'b0}, 1'b0, none});
      table_rows.push_back('{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b0, none});
      table_rows.push_back('{'{16'd0, 16'd1, 16'd7, 1'b0}, 1'b0, none});
      table_rows.push_back('{'{16'd0, 16'd0, 16'd7, 1'b1}, 1'b0, none});
      table_rows.push_back('{'{16'd3, 16'd6, 16'hFFFF, 1'b0}, 1'b0, none});
      table_rows.push_back('{'{16'd3, 16'd6, 16'd1, 1'b1}, 1'b0, none});
      foreach (table_rows[i]) send_child(table_rows[i].c, table_rows[i].chk, table_rows[i].want);
      drain_then_wait();

      write_csr(CsrMode, 16'(ModeRate));
      table_rows.delete();
      table_rows.push_back('{'{16'd0, 16'd0, 16'd0, 1'b1}, 1'b1, '{8'd0, 32'd0, 1'b0, 1'b0}});
      table_rows.push_back('{'{16'd1, 16'd2, 16'd3, 1'b0}, 1'b0, none});
      table_rows.push_back('{'{16'd2, 16'd4, 16'd3, 1'b0}, 1'b0, none});
      table_rows.push_back('{'{16'd7, 16'd7, 16'd3, 1'b1}, 1'b1, '{8'd2, 32'h10000, 1'b0, 1'b0}});
      foreach (table_rows[i]) send_child(table_rows[i].c, table_rows[i].chk, table_rows[i].want);
      drain_then_wait();

      write_csr(CsrMode, 16'(ModeVisits));
      table_rows.delete();
      table_rows.push_back('{'{16'd0, 16'hFFFF, 16'd0, 1'b0}, 1'b0, none});
      table_rows.push_back('{'{16'd0, 16'hFFFF, 16'd0, 1'b1}, 1'b1, '{8'd0, 32'hFFFF, 1'b0, 1'b0}});
      foreach (table_rows[i]) send_child(table_rows[i].c, table_rows[i].chk, table_rows[i].want);
      drain_then_wait();

      // Unused mode three acts as visits; mode changes within a pass.
      write_csr(CsrMode, 16'd3);
      send_child('{16'd0, 16'd9, 16'd4, 1'b0}, 1'b0, none);
      repeat (40) @(posedge clock);
      write_csr(CsrMode, 16'(ModeUct));
      send_child('{16'd0, 16'd0, 16'd4, 1'b1}, 1'b1, '{8'd1, ScoreInf, 1'b0, 1'b0});
      drain_then_wait();

      // Overflow: a pass longer than the child limit, in visits mode.
      write_csr(CsrMode, 16'(ModeVisits));
      for (int i = 0; i < MaxChildren + 2; i++) begin
         c = random_child(MaxChildren + 1 - i);
         send_child(c, 1'b0, none);
      end
      drain_then_wait();

      sent = 0;
      n_left = 0;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0; recv_idle = 0; end
            1: begin send_idle = 63; recv_idle = 0; end
            2: begin send_idle = 0; recv_idle = 63; end
            default: begin send_idle = 19; recv_idle = 19; end
         endcase
         drain_then_wait();
         write_csr(CsrMode, 16'((ph < 4) ? ModeUct : ((ph == 5) ? ModeRate : 16'(ph % 4))));
         write_csr(CsrExpC, (ph == 0) ? 16'd0 : (ph == 1) ? 16'hFFFF : 16'($urandom));
         for (int i = 0; i < 170; i++) begin
            if (n_left == 0) n_left = $urandom_range(0, 5);
            else n_left--;
            c = random_child(n_left);
            send_child(c, 1'b0, none);
            sent++;
         end
         if (ph == 2) begin
            long_hold = 1'b1;
            fork
               begin
                  for (hold = 0; hold < 3000; hold++) @(posedge clock);
                  long_hold = 1'b0;
               end
               for (int i = 0; i < 20; i++) begin
                  c = random_child((i % 2 == 0) ? 1 : 0);
                  send_child(c, 1'b0, none);
               end
            join
         end
         // Finish any open pass before changing settings.
         if (n_left != 0) begin
            c = random_child(0);
            send_child(c, 1'b0, none);
            n_left = 0;
         end
      end
      send_idle = 0;
      recv_idle = 0;
      drain_then_wait();
      if (pending_picks.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_picks.size());
         errors++;
      end
      $display("Covered directed edge cases, overflow, all modes and %0d random children;", sent);
      $display("%0d selections compared under varied stall patterns.", picks_seen);
      if (errors == 0) begin
         $display("mcts_child_selector_tb: clean");
      end else begin
         $display("mcts_child_selector_tb: errors");
      end
      $finish;
   end

endmodule
